FILE: rtl/move_to_front_coder_assert.svh
// assertion helpers for the move-to-front coder
`ifndef MOVE_TO_FRONT_CODER_ASSERT_SVH
`define MOVE_TO_FRONT_CODER_ASSERT_SVH

// same-cycle implication
`define MTFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("move_to_front_coder assertion failed");

// next-cycle implication
`define MTFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("move_to_front_coder assertion failed");

`endif

FILE: rtl/mtfc_pkg.sv
package mtfc_pkg;

  localparam int unsigned LIST_SIZE_DEF = 256;
  localparam int unsigned SYM_W         = 8;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned ADDR_W        = 3;

  localparam logic [SYM_W-1:0] MISS_CODE = 8'hFF;

  // register index, taken from paddr[2]
  localparam logic REG_DECODE_MODE = 1'b0;

  // token walking the cell chain
  typedef struct packed {
    logic             valid;
    logic             done;
    logic             miss;
    logic [SYM_W-1:0] carry;
    logic [SYM_W-1:0] pos;
  } tok_t;

endpackage

FILE: rtl/move_to_front_coder.sv
// an accepted symbol is registered as a token, walks the LIST_SIZE cells
//   to res_r and is loaded into the output once it is free; no new symbol
//   is taken until then, as one token walks the whole chain of list cells
//   before the front entry is written back. Synchronous reset (rst_n low):
//   identity list, decode_mode to 0, no transfer pending on either side
module move_to_front_coder #(
  parameter int unsigned LIST_SIZE = mtfc_pkg::LIST_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mtfc_pkg::SYM_W-1:0]  in_symbol_in,
  input  logic                        in_block_start,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mtfc_pkg::SYM_W-1:0]  out_symbol_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mtfc_pkg::ADDR_W-1:0] paddr,
  input  logic [mtfc_pkg::DATA_W-1:0] pwdata,
  output logic [mtfc_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [mtfc_pkg::SYM_W:0]   SIZE_EXT = (mtfc_pkg::SYM_W+1)'(LIST_SIZE);
  localparam logic [mtfc_pkg::SYM_W-1:0] LAST_POS = mtfc_pkg::SYM_W'(LIST_SIZE - 1);

  logic [1:0]                 state_r;
  logic [1:0]                 state_nxt;
  logic                       mode_r;
  logic [mtfc_pkg::SYM_W-1:0] key_r;
  logic [mtfc_pkg::SYM_W-1:0] key_nxt;
  mtfc_pkg::tok_t             inj_r;
  mtfc_pkg::tok_t             inj_nxt;
  logic [mtfc_pkg::SYM_W-1:0] res_r;
  logic [mtfc_pkg::SYM_W-1:0] res_nxt;
  logic                       out_valid_r;
  logic [mtfc_pkg::SYM_W-1:0] out_symbol_r;
  logic                       accept;
  logic                       restore;
  logic                       cfg_wr;
  logic                       out_free;
  logic                       out_load;
  logic                       front_wr;
  logic                       out_of_range;
  mtfc_pkg::tok_t             chain [LIST_SIZE+1];
  mtfc_pkg::tok_t             exit_tok;
  logic [LIST_SIZE:0]         tok_v;

  assign accept       = in_valid && !in_stall;
  assign restore      = accept && in_block_start;
  assign in_stall     = (state_r != ST_IDLE);
  assign out_of_range = ({1'b0, in_symbol_in} >= SIZE_EXT);
  assign cfg_wr       = psel && penable && pwrite && pready &&
                        (paddr[2] == mtfc_pkg::REG_DECODE_MODE);
  assign pready       = 1'b1;
  assign prdata       = (paddr[2] == mtfc_pkg::REG_DECODE_MODE) ?
                        {{(mtfc_pkg::DATA_W-1){1'b0}}, mode_r} : '0;

  assign exit_tok = chain[LIST_SIZE];
  assign front_wr = exit_tok.valid && exit_tok.done && !exit_tok.miss;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == ST_DONE) && out_free;

  // token injection into the head cell
  always_comb begin
    inj_nxt = '0;
    key_nxt = key_r;
    if (accept) begin
      inj_nxt.valid = 1'b1;
      if (mode_r) begin
        key_nxt = out_of_range ? LAST_POS : in_symbol_in;
      end else begin
        key_nxt      = in_symbol_in;
        inj_nxt.miss = out_of_range;
        inj_nxt.done = out_of_range;
      end
    end
  end

  always_comb begin
    res_nxt = res_r;
    if (exit_tok.valid) begin
      if (exit_tok.miss) begin
        res_nxt = mtfc_pkg::MISS_CODE;
      end else if (mode_r) begin
        res_nxt = exit_tok.carry;
      end else begin
        res_nxt = exit_tok.pos;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (exit_tok.valid) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= 1'b0;
      inj_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      inj_r   <= inj_nxt;
      if (cfg_wr) mode_r <= pwdata[0];
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    res_r <= res_nxt;
    if (out_load) out_symbol_r <= res_r;
  end

  assign out_valid      = out_valid_r;
  assign out_symbol_out = out_symbol_r;

  assign chain[0] = inj_r;

  for (genvar i = 0; i < LIST_SIZE; i++) begin : g_cell
    mtfc_cell #(
      .CELL_IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .restore   (restore),
      .mode      (mode_r),
      .key       (key_r),
      .load_en   ((i == 0) ? front_wr : 1'b0),
      .load_data (exit_tok.carry),
      .tok_in    (chain[i]),
      .tok_out   (chain[i+1])
    );
  end

  for (genvar i = 0; i <= LIST_SIZE; i++) begin : g_tok_v
    assign tok_v[i] = chain[i].valid;
  end

  `include "move_to_front_coder_assert.svh"

  `MTFC_ASSERT_NOW(a_single_token, clk, rst_n, 1'b1, $onehot0(tok_v))
  `MTFC_ASSERT_NOW(a_idle_chain_empty, clk, rst_n, state_r == ST_IDLE, tok_v == '0)
  `MTFC_ASSERT_NOW(a_exit_in_run, clk, rst_n, exit_tok.valid, state_r == ST_RUN)
  `MTFC_ASSERT_NEXT(a_accept_injects, clk, rst_n, accept, inj_r.valid && state_r == ST_RUN)

endmodule

FILE: rtl/mtfc_cell.sv
module mtfc_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     restore,
  input  logic                     mode,
  input  logic [mtfc_pkg::SYM_W-1:0] key,
  input  logic                     load_en,
  input  logic [mtfc_pkg::SYM_W-1:0] load_data,
  input  mtfc_pkg::tok_t           tok_in,
  output mtfc_pkg::tok_t           tok_out
);

  localparam logic [mtfc_pkg::SYM_W-1:0] IDX = mtfc_pkg::SYM_W'(CELL_IDX);
  localparam bit IS_HEAD = (CELL_IDX == 0);

  logic [mtfc_pkg::SYM_W-1:0] entry_r;
  logic [mtfc_pkg::SYM_W-1:0] entry_nxt;
  mtfc_pkg::tok_t             tok_r;
  mtfc_pkg::tok_t             tok_nxt;
  logic                       active;
  logic                       hit;

  assign active = tok_in.valid && !tok_in.done;
  assign hit    = active && (mode ? (key == IDX) : (entry_r == key));

  always_comb begin
    entry_nxt = entry_r;
    if (restore) begin
      entry_nxt = IDX;
    end else if (load_en) begin
      entry_nxt = load_data;
    end else if (active && !IS_HEAD) begin
      entry_nxt = tok_in.carry;
    end
  end

  always_comb begin
    tok_nxt = tok_in;
    if (active) begin
      tok_nxt.carry = entry_r;
      if (hit) begin
        tok_nxt.done = 1'b1;
        tok_nxt.pos  = IDX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= IDX;
      tok_r   <= '0;
    end else begin
      entry_r <= entry_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule
